>>> rtl/sust_pkg.sv
// shared types and codes for the sorted unique set table
package sust_pkg;

    // input and result field widths
    localparam int ACTION_W = 2;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 4;
    localparam int CNT_W    = 5;

    // packed stream widths, rounded up to whole bytes
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    typedef logic [ACTION_W-1:0]     action_t;
    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [STATUS_W-1:0]     status_t;

    // operation codes (code 3 acts as search)
    localparam action_t ACT_INSERT = 2'd0;
    localparam action_t ACT_DELETE = 2'd1;
    localparam action_t ACT_SEARCH = 2'd2;

    // result status codes
    localparam status_t ST_INSERTED  = 3'd0;
    localparam status_t ST_DUPLICATE = 3'd1;
    localparam status_t ST_DELETED   = 3'd2;
    localparam status_t ST_NOT_FOUND = 3'd3;
    localparam status_t ST_FOUND     = 3'd4;
    localparam status_t ST_FULL      = 3'd5;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic ins;
        logic del;
        key_t key;
    } cell_cmd_t;

endpackage

>>> rtl/sust_cell.sv
// one storage cell of the sorted row: compare against the key and shift
module sust_cell
    import sust_pkg::*;
(
    input  logic      clk,
    input  logic      valid,
    input  cell_cmd_t cmd,
    input  logic      left_lt,
    input  key_t      left_entry,
    input  key_t      right_entry,
    output logic      lt,
    output logic      eq,
    output key_t      entry
);

    key_t entry_reg;
    key_t entry_next;

    // parallel compare against the broadcast key
    assign lt    = valid && (entry_reg < cmd.key);
    assign eq    = valid && (entry_reg == cmd.key);
    assign entry = entry_reg;

    // insert opens a gap at the rank, delete closes it
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins && !lt)
        begin
            entry_next = left_lt ? cmd.key : left_entry;
        end
        else if (cmd.del && !lt)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

>>> rtl/sorted_unique_set_table.sv
// sorted unique set table: row of compare-and-shift cells with stream ports
//
//  channel | direction | fields (tdata, lowest bit first)
//  s_*     | in        | action[1:0], value[33:2], zero fill to 40 bits
//  m_*     | out       | status[2:0], position[6:3], count[11:7], zero fill
//
// each transaction has two steps: one captures the item, one in which every
// cell compares against the key at once and the row shifts by one on a
// successful insert or delete. the result then sits in an output register;
// the next item is taken while it waits. reset clears the entry count, the
// control state and the output valid; cell contents stay undefined and are
// never read before they are written. a stalled output holds the item in the
// execute step until the output register frees up.
module sorted_unique_set_table
    import sust_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // action, value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata   // status, position, count
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    action_t               act_reg;
    key_t                  key_reg;
    logic [CW-1:0]         held_reg, held_next;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [CAPACITY-1:0] lt_vec;
    logic [CAPACITY-1:0] eq_vec;
    key_t                entry_vec [CAPACITY];
    logic [CW-1:0]       rank;
    logic                present;
    logic                full;
    logic                exec_fire;
    logic                ins_ok;
    logic                del_ok;
    status_t             status;
    logic [POS_W-1:0]    pos;
    cell_cmd_t           cmd;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // item capture
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            act_reg <= s_tdata[ACTION_W-1:0];
            key_reg <= s_tdata[ACTION_W+KEY_W-1:ACTION_W];
        end
    end

    // row of cells
    assign cmd.ins = ins_ok;
    assign cmd.del = del_ok;
    assign cmd.key = key_reg;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        sust_cell u_cell (
            .clk         (clk),
            .valid       (held_reg > CW'(i)),
            .cmd         (cmd),
            .left_lt     ((i == 0) ? 1'b1 : lt_vec[(i == 0) ? 0 : i-1]),
            .left_entry  (entry_vec[(i == 0) ? 0 : i-1]),
            .right_entry (entry_vec[(i == CAPACITY-1) ? i : i+1]),
            .lt          (lt_vec[i]),
            .eq          (eq_vec[i]),
            .entry       (entry_vec[i])
        );
    end

    // rank from the edge of the below-key thermometer
    always_comb
    begin
        rank = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (lt_vec[i] && ((i == CAPACITY-1) || !lt_vec[(i == CAPACITY-1) ? i : i+1]))
            begin
                rank = rank | CW'(i + 1);
            end
        end
    end

    assign present   = |eq_vec;
    assign full      = (held_reg == CW'(CAPACITY));
    assign exec_fire = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);
    assign ins_ok    = exec_fire && (act_reg == ACT_INSERT) && !present && !full;
    assign del_ok    = exec_fire && (act_reg == ACT_DELETE) && present;

    // result status and position
    always_comb
    begin
        status = ST_NOT_FOUND;
        pos    = '0;
        case (act_reg)
            ACT_INSERT:
            begin
                if (present)
                begin
                    status = ST_DUPLICATE;
                    pos    = POS_W'(rank);
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    status = ST_INSERTED;
                    pos    = POS_W'(rank);
                end
            end
            ACT_DELETE:
            begin
                if (present)
                begin
                    status = ST_DELETED;
                    pos    = POS_W'(rank);
                end
            end
            default:
            begin
                if (present)
                begin
                    status = ST_FOUND;
                    pos    = POS_W'(rank);
                end
            end
        endcase
    end

    // entry count
    always_comb
    begin
        held_next = held_reg;
        if (ins_ok)
        begin
            held_next = held_reg + CW'(1);
        end
        else if (del_ok)
        begin
            held_next = held_reg - CW'(1);
        end
    end

    // control sequence
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            out_data_reg <= OUT_DATA_W'({CNT_W'(held_next), pos, status});
        end
    end

`ifndef NO_ASSERTIONS
    // count never passes the capacity
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // a held key matches at most one cell
    a_eq_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(eq_vec))
        else $error("key matched in more than one cell");

    // row stays sorted: below-key cells form a prefix
    a_lt_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((lt_vec >> 1) & ~lt_vec) == '0)
        else $error("row order broken");

    // a successful insert grows the count by one
    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        ins_ok |=> held_reg == $past(held_reg) + CW'(1))
        else $error("insert did not grow count");

    // every execute step leaves a result in the output register
    a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> m_tvalid)
        else $error("result lost after execute");
`endif

endmodule

>>> tb/sv/sorted_unique_set_table_test.sv
// self-checking stream testbench for the sorted unique set table
`timescale 1ns / 100ps

module sorted_unique_set_table_test
    import sust_pkg::*;
();

    localparam int SET_CAPACITY = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int POOL_SIZE    = 20;

    // code 3 has no name in the package and is handled as a search
    localparam action_t ACT_UNUSED = 2'd3;

    typedef struct {
        action_t action;
        key_t    value;
    } set_op_t;

    typedef struct {
        status_t          status;
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] held_after;
    } set_result_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // ops waiting to be sent and results still owed by the block
    set_op_t     pending_ops[$];
    set_result_t expected_results[$];

    // shadow copy of the sorted set
    key_t        set_keys[SET_CAPACITY];
    int unsigned set_size = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int cycle_count    = 0;

    key_t key_pool[POOL_SIZE];

    sorted_unique_set_table #(
        .CAPACITY (SET_CAPACITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // apply one op to the shadow set and queue the result it must give
    function automatic void apply_set_op(set_op_t op);
        int unsigned rank;
        bit          present;
        set_result_t res;
        rank = 0;
        for (int i = 0; i < set_size; i++)
        begin
            if (set_keys[i] < op.value)
                rank++;
        end
        present      = (rank < set_size) && (set_keys[rank] == op.value);
        res.position = '0;
        case (op.action)
            ACT_INSERT:
            begin
                if (present)
                begin
                    res.status   = ST_DUPLICATE;
                    res.position = rank[POS_W-1:0];
                end
                else if (set_size >= SET_CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    for (int i = set_size; i > rank; i--)
                        set_keys[i] = set_keys[i-1];
                    set_keys[rank] = op.value;
                    set_size++;
                    res.status   = ST_INSERTED;
                    res.position = rank[POS_W-1:0];
                end
            end
            ACT_DELETE:
            begin
                if (present)
                begin
                    for (int i = rank; i + 1 < set_size; i++)
                        set_keys[i] = set_keys[i+1];
                    set_size--;
                    res.status   = ST_DELETED;
                    res.position = rank[POS_W-1:0];
                end
                else
                    res.status = ST_NOT_FOUND;
            end
            default:
            begin
                if (present)
                begin
                    res.status   = ST_FOUND;
                    res.position = rank[POS_W-1:0];
                end
                else
                    res.status = ST_NOT_FOUND;
            end
        endcase
        res.held_after = set_size[CNT_W-1:0];
        expected_results.push_back(res);
    endfunction

    function automatic void add_op(action_t act, key_t val);
        set_op_t op;
        op.action = act;
        op.value  = val;
        pending_ops.push_back(op);
    endfunction

    // random ops over a small key pool so hits, duplicates and a full set all occur
    function automatic void add_random_ops(int n);
        int ins_pct;
        int pick;
        action_t act;
        key_t val;
        ins_pct = 50;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = key_t'($urandom);
        key_pool[0] = 32'sh80000000;
        key_pool[1] = 32'sh7FFFFFFF;
        key_pool[2] = '0;
        key_pool[3] = '1;
        for (int i = 0; i < n; i++)
        begin
            // swing between filling and draining the set
            if (i % 60 == 0)
                ins_pct = $urandom_range(75, 25);
            pick = $urandom_range(99);
            if (pick < 3)
                act = ACT_UNUSED;
            else if (pick < 3 + ins_pct)
                act = ACT_INSERT;
            else if (pick < 3 + ins_pct + (97 - ins_pct) / 2)
                act = ACT_DELETE;
            else
                act = ACT_SEARCH;
            if ($urandom_range(99) < 88)
                val = key_pool[$urandom_range(POOL_SIZE - 1)];
            else
                val = key_t'($urandom);
            add_op(act, val);
        end
    endfunction

    // sender: one transaction per handshake, random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            set_op_t op;
            if (s_tvalid && s_tready)
            begin
                op.action = s_tdata[ACTION_W-1:0];
                op.value  = s_tdata[ACTION_W +: KEY_W];
                apply_set_op(op);
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    op = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(IN_DATA_W - KEY_W - ACTION_W){1'b0}}, op.value, op.action};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls and field-by-field check of each result
    always @(posedge clk)
    begin
        set_result_t want;
        set_result_t got;
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status     = m_tdata[STATUS_W-1:0];
            got.position   = m_tdata[STATUS_W +: POS_W];
            got.held_after = m_tdata[STATUS_W + POS_W +: CNT_W];
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: status %0d position %0d count %0d",
                       got.status, got.position, got.held_after);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    error_count++;
                end
                if (got.position !== want.position)
                begin
                    $error("position: expected %0d, got %0d", want.position, got.position);
                    error_count++;
                end
                if (got.held_after !== want.held_after)
                begin
                    $error("count: expected %0d, got %0d", want.held_after, got.held_after);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // phase 1: sender rarely idles, receiver stalls often
        send_idle_pct  = 8;
        recv_stall_pct = 67;

        // directed: empty set, extremes, duplicate, code 3, full set, edge deletes
        add_op(ACT_SEARCH, 32'sd5);
        add_op(ACT_DELETE, 32'sd5);
        add_op(ACT_INSERT, 32'sd0);
        add_op(ACT_INSERT, -32'sd1);
        add_op(ACT_INSERT, 32'sh7FFFFFFF);
        add_op(ACT_INSERT, 32'sh80000000);
        add_op(ACT_INSERT, 32'sd0);
        add_op(ACT_SEARCH, 32'sh80000000);
        add_op(ACT_UNUSED, -32'sd1);
        for (int i = 0; i < SET_CAPACITY - 4; i++)
            add_op(ACT_INSERT, key_t'(i * 1000 - 5500));
        add_op(ACT_INSERT, 32'sd12345);
        add_op(ACT_INSERT, 32'sd0);
        add_op(ACT_DELETE, 32'sh7FFFFFFF);
        add_op(ACT_DELETE, 32'sh80000000);
        add_op(ACT_DELETE, 32'sd77);

        add_random_ops(505);
        while (pending_ops.size() != 0)
            @(negedge clk);

        // phase 2: sender idles often, receiver rarely stalls
        send_idle_pct  = 67;
        recv_stall_pct = 8;
        add_random_ops(505);
        while (pending_ops.size() != 0)
            @(negedge clk);

        // phase 3: full rate both ways
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        add_random_ops(510);

        // drain
        while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/sust_pkg.sv
rtl/sust_cell.sv
rtl/sorted_unique_set_table.sv
tb/sv/sorted_unique_set_table_test.sv
